// File: rtl/ordt_pkg.sv
// Shared types and constants for the ordered array table.
package ordt_pkg;

  // Fixed field widths of the transfer channels
  localparam int ACT_W     = 4;
  localparam int POS_W     = 8;
  localparam int WORD_W    = 32;
  localparam int CNT_OUT_W = 9;

  // Default sizing
  localparam int DEPTH_DEF     = 256;
  localparam int WORD_BITS_DEF = 32;

  // Operation codes
  typedef enum logic [ACT_W-1:0] {
    ACT_GET    = 4'd0,
    ACT_SET    = 4'd1,
    ACT_PUSH   = 4'd2,
    ACT_POP    = 4'd3,
    ACT_INSERT = 4'd4,
    ACT_REMOVE = 4'd5,
    ACT_FRONT  = 4'd6,
    ACT_BACK   = 4'd7,
    ACT_CLEAR  = 4'd8
  } act_t;

endpackage

// File: rtl/ordt_ifs.sv
// Request and response channel interfaces of the ordered array table.
interface ordt_req_if import ordt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ACT_W-1:0]     action;
  logic [POS_W-1:0]     position;
  logic [WORD_W-1:0]    word_in;

  modport source (output valid, action, position, word_in, input ready);
  modport sink   (input valid, action, position, word_in, output ready);
endinterface

interface ordt_rsp_if import ordt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [WORD_W-1:0]    word_out;
  logic [CNT_OUT_W-1:0] count_now;
  logic                 is_empty;

  modport source (output valid, ok, word_out, count_now, is_empty, input ready);
  modport sink   (input valid, ok, word_out, count_now, is_empty, output ready);
endinterface

// File: rtl/ordt_mem.sv
// Entry storage: one write port, one read port with registered read data.
module ordt_mem import ordt_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int ADDR_W   = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ordt_ctrl.sv
// Operation sequencer: decodes requests, walks the memory for shifts, holds the response.
module ordt_ctrl import ordt_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  localparam int ADDR_W   = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  ordt_req_if.sink             req,
  ordt_rsp_if.source           rsp,
  output logic                 mem_wr_en,
  output logic [ADDR_W-1:0]    mem_wr_addr,
  output logic [WORD_BITS-1:0] mem_wr_data,
  output logic                 mem_rd_en,
  output logic [ADDR_W-1:0]    mem_rd_addr,
  input  logic [WORD_BITS-1:0] mem_rd_data
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINAL, S_RESP} state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  act_t                 op;
  logic [ADDR_W-1:0]    cur;
  logic [ADDR_W-1:0]    last;
  logic [ADDR_W-1:0]    ins_pos;
  logic [WORD_BITS-1:0] ins_word;
  logic                 issuing;
  logic                 first;
  logic                 lag_valid;
  logic                 lag_first;
  logic [ADDR_W-1:0]    lag_addr;
  logic                 res_ok;
  logic [WORD_BITS-1:0] res_word;

  logic                 out_valid;
  logic                 out_ok;
  logic [WORD_W-1:0]    out_word;
  logic [CNT_OUT_W-1:0] out_cnt;
  logic                 out_empty;

  // Decode of the incoming request
  logic                       fire;
  logic [CMP_W-1:0]           pos_ext;
  logic [CMP_W-1:0]           cnt_ext;
  logic                       in_range;
  logic                       not_empty;
  logic                       not_full;
  logic [ADDR_W-1:0]          pos_addr;
  logic [ADDR_W-1:0]          cnt_addr;
  logic [ADDR_W-1:0]          cnt_last;
  logic [WORD_BITS+WORD_W-1:0] word_wide;
  logic [WORD_BITS-1:0]       word_st;
  logic                       dec_ok;
  logic                       dec_run;
  logic                       dec_wr;
  logic [ADDR_W-1:0]          dec_wr_addr;
  logic [ADDR_W-1:0]          dec_start;
  logic [ADDR_W-1:0]          dec_last;
  logic [CNT_W-1:0]           dec_cnt;

  // Shift write-back and response load
  logic                       lag_wr;
  logic                       load;
  logic [WORD_BITS+WORD_W-1:0] res_wide;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

  assign fire      = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    pos_ext   = CMP_W'(req.position);
    cnt_ext   = CMP_W'(count);
    in_range  = pos_ext < cnt_ext;
    not_empty = (count != '0);
    not_full  = (count != CNT_W'(DEPTH));
    pos_addr  = ADDR_W'(req.position);
    cnt_addr  = ADDR_W'(count);
    cnt_last  = ADDR_W'(count - CNT_W'(1));
    word_wide = {{WORD_BITS{1'b0}}, req.word_in};
    word_st   = word_wide[WORD_BITS-1:0];

    dec_ok      = 1'b0;
    dec_run     = 1'b0;
    dec_wr      = 1'b0;
    dec_wr_addr = pos_addr;
    dec_start   = pos_addr;
    dec_last    = pos_addr;
    dec_cnt     = count;
    case (req.action)
      ACT_GET: begin
        dec_ok  = in_range;
        dec_run = in_range;
      end
      ACT_SET: begin
        dec_ok = in_range;
        dec_wr = in_range;
      end
      ACT_PUSH: begin
        dec_ok      = not_full;
        dec_wr      = not_full;
        dec_wr_addr = cnt_addr;
        if (not_full) dec_cnt = count + CNT_W'(1);
      end
      ACT_POP: begin
        dec_ok    = not_empty;
        dec_run   = not_empty;
        dec_start = cnt_last;
        dec_last  = cnt_last;
        if (not_empty) dec_cnt = count - CNT_W'(1);
      end
      ACT_INSERT: begin
        dec_ok      = not_full;
        // past the end: plain append; otherwise shift from the top down
        dec_wr      = not_full && !in_range;
        dec_run     = not_full && in_range;
        dec_wr_addr = cnt_addr;
        dec_start   = cnt_last;
        dec_last    = pos_addr;
        if (not_full) dec_cnt = count + CNT_W'(1);
      end
      ACT_REMOVE: begin
        dec_ok   = in_range;
        dec_run  = in_range;
        dec_last = cnt_last;
        if (in_range) dec_cnt = count - CNT_W'(1);
      end
      ACT_FRONT: begin
        dec_ok    = not_empty;
        dec_run   = not_empty;
        dec_start = '0;
        dec_last  = '0;
      end
      ACT_BACK: begin
        dec_ok    = not_empty;
        dec_run   = not_empty;
        dec_start = cnt_last;
        dec_last  = cnt_last;
      end
      ACT_CLEAR: begin
        dec_ok  = 1'b1;
        dec_cnt = '0;
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  // Shift step: data read last cycle is written one place up (insert) or down (remove)
  assign lag_wr = lag_valid && ((op == ACT_INSERT) || ((op == ACT_REMOVE) && !lag_first));

  // Memory port steering
  always_comb begin
    mem_rd_en   = (state == S_RUN) && issuing;
    mem_rd_addr = cur;
    mem_wr_en   = 1'b0;
    mem_wr_addr = dec_wr_addr;
    mem_wr_data = word_st;
    if (state == S_IDLE) begin
      mem_wr_en = fire && dec_wr;
    end else if (state == S_RUN) begin
      mem_wr_en   = lag_wr;
      mem_wr_addr = (op == ACT_INSERT) ? lag_addr + ADDR_W'(1) : lag_addr - ADDR_W'(1);
      mem_wr_data = mem_rd_data;
    end else if (state == S_FINAL) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = ins_pos;
      mem_wr_data = ins_word;
    end
  end

  assign load     = (state == S_RESP) && (!out_valid || rsp.ready);
  assign res_wide = {{WORD_W{1'b0}}, res_word};
  assign cnt_wide = {{CNT_OUT_W{1'b0}}, count};

  // Sequencer state and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issuing   <= 1'b0;
      lag_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a response taken with no new one loaded empties the register
      if (out_valid && rsp.ready && !load) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (fire) begin
            op       <= act_t'(req.action);
            count    <= dec_cnt;
            res_ok   <= dec_ok;
            res_word <= '0;
            cur      <= dec_start;
            last     <= dec_last;
            ins_pos  <= pos_addr;
            ins_word <= word_st;
            issuing  <= dec_run;
            first    <= 1'b1;
            state    <= dec_run ? S_RUN : S_RESP;
          end
        end
        S_RUN: begin
          if (issuing) begin
            first <= 1'b0;
            if (cur == last) begin
              issuing <= 1'b0;
            end else begin
              cur <= (op == ACT_INSERT) ? cur - ADDR_W'(1) : cur + ADDR_W'(1);
            end
          end
          lag_valid <= issuing;
          lag_first <= first;
          lag_addr  <= cur;
          // first word read is the answer for every read-type operation
          if (lag_valid && lag_first && (op != ACT_INSERT)) res_word <= mem_rd_data;
          if (!issuing && lag_valid) state <= (op == ACT_INSERT) ? S_FINAL : S_RESP;
        end
        S_FINAL: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (load) begin
            out_valid <= 1'b1;
            out_ok    <= res_ok;
            out_word  <= res_wide[WORD_W-1:0];
            out_cnt   <= cnt_wide[CNT_OUT_W-1:0];
            out_empty <= (count == '0);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.ok        = out_ok;
  assign rsp.word_out  = out_word;
  assign rsp.count_now = out_cnt;
  assign rsp.is_empty  = out_empty;

  // Count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds capacity");

  // Shift reads and write-backs never touch the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr)))
    else $error("read and write to the same entry in one cycle");

  // A transfer in always starts work
  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    fire |=> (state != S_IDLE))
    else $error("request taken but sequencer stayed idle");

  // Pending read data only exists while walking the memory
  a_lag_in_run: assert property (@(posedge clk) disable iff (rst)
    lag_valid |-> (state == S_RUN))
    else $error("read data pending outside a memory walk");

endmodule

// File: rtl/ordered_array_table.sv
// Top level of the ordered array table: sequencer plus entry memory.
//
//  channel | dir | transfer carries
//  --------+-----+------------------------------------------
//  req     | in  | action, position, word_in
//  rsp     | out | ok, word_out, count_now, is_empty
//
// One request at a time. Set, push, clear and failed operations do not
// walk the memory; single reads (get, pop, front, back) read one entry.
// Inserts inside the table and removes walk it one entry per cycle through
// its single read port; the longest walk is an insert or remove at 0.
// Reset clears the count; entries are undefined until written.
// A stalled response is held in its register while the next request is taken.
module ordered_array_table import ordt_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ordt_req_if.sink   req,
  ordt_rsp_if.source rsp
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic                 mem_wr_en;
  logic [ADDR_W-1:0]    mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [ADDR_W-1:0]    mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;

  ordt_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ordt_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// File: tb/ordered_array_table_test.sv
// Self-checking testbench for the ordered array table: directed table, then random traffic.
module ordered_array_table_test;
  import ordt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH    = DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int DIR_ROWS       = 25;

  // Codes outside the operation set; the block must reject them
  localparam logic [ACT_W-1:0] ACT_UNKNOWN_LO = 4'd9;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    logic                 ok;
    logic [WORD_W-1:0]    word_out;
    logic [CNT_OUT_W-1:0] count_now;
    logic                 is_empty;
  } op_result_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    logic              typed;
    op_result_t        res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ordt_req_if req_ch ();
  ordt_rsp_if rsp_ch ();

  ordered_array_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the table contents and count
  logic [WORD_W-1:0] table_words [TABLE_DEPTH];
  int                table_count;

  op_result_t pending_results [$];
  int         error_count = 0;
  int         idle_cycles = 0;
  int         ready_hold = 0;
  bit         stalls_on;

  // Directed stimulus; typed rows carry a fixed expected result
  dir_row_t directed [DIR_ROWS] = '{
    '{ACT_GET,        8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd0, 1'b1}},
    '{ACT_POP,        8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd0, 1'b1}},
    '{ACT_FRONT,      8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd0, 1'b1}},
    '{ACT_BACK,       8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd0, 1'b1}},
    '{ACT_SET,        8'd0,   32'h1234_5678, 1'b1, '{1'b0, 32'h0, 9'd0, 1'b1}},
    '{ACT_REMOVE,     8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd0, 1'b1}},
    '{ACT_PUSH,       8'd0,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 9'd1, 1'b0}},
    '{ACT_PUSH,       8'd255, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 9'd2, 1'b0}},
    '{ACT_GET,        8'd0,   32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 9'd2, 1'b0}},
    '{ACT_GET,        8'd1,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 9'd2, 1'b0}},
    '{ACT_GET,        8'd2,   32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd2, 1'b0}},
    '{ACT_INSERT,     8'd0,   32'hA5A5_A5A5, 1'b0, '0},
    '{ACT_INSERT,     8'd255, 32'h5A5A_5A5A, 1'b0, '0},
    '{ACT_INSERT,     8'd1,   32'hDEAD_BEEF, 1'b0, '0},
    '{ACT_SET,        8'd255, 32'h0BAD_F00D, 1'b1, '{1'b0, 32'h0, 9'd5, 1'b0}},
    '{ACT_SET,        8'd2,   32'h0F0F_0F0F, 1'b0, '0},
    '{ACT_FRONT,      8'd0,   32'h0000_0000, 1'b0, '0},
    '{ACT_BACK,       8'd0,   32'h0000_0000, 1'b0, '0},
    '{ACT_REMOVE,     8'd0,   32'h0000_0000, 1'b0, '0},
    '{ACT_REMOVE,     8'd3,   32'h0000_0000, 1'b0, '0},
    '{ACT_POP,        8'd0,   32'h0000_0000, 1'b0, '0},
    '{ACT_UNKNOWN_LO, 8'd0,   32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 9'd2, 1'b0}},
    '{ACT_UNKNOWN_HI, 8'd255, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 9'd2, 1'b0}},
    '{ACT_CLEAR,      8'd0,   32'h0000_0000, 1'b1, '{1'b1, 32'h0, 9'd0, 1'b1}},
    '{ACT_POP,        8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0, 9'd0, 1'b1}}
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the shadow table and return its response
  function automatic op_result_t apply_op(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                          logic [WORD_W-1:0] word);
    op_result_t r;
    int         p;
    r  = '0;
    p  = pos;
    case (act)
      ACT_GET: begin
        if (p < table_count) begin
          r.ok       = 1'b1;
          r.word_out = table_words[p];
        end
      end
      ACT_SET: begin
        if (p < table_count) begin
          table_words[p] = word;
          r.ok           = 1'b1;
        end
      end
      ACT_PUSH: begin
        if (table_count < TABLE_DEPTH) begin
          table_words[table_count] = word;
          table_count++;
          r.ok = 1'b1;
        end
      end
      ACT_POP: begin
        if (table_count > 0) begin
          table_count--;
          r.ok       = 1'b1;
          r.word_out = table_words[table_count];
        end
      end
      ACT_INSERT: begin
        if (table_count < TABLE_DEPTH) begin
          if (p >= table_count) begin
            table_words[table_count] = word;
          end else begin
            for (int k = table_count; k > p; k--) table_words[k] = table_words[k-1];
            table_words[p] = word;
          end
          table_count++;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (p < table_count) begin
          r.ok       = 1'b1;
          r.word_out = table_words[p];
          for (int k = p; k + 1 < table_count; k++) table_words[k] = table_words[k+1];
          table_count--;
        end
      end
      ACT_FRONT: begin
        if (table_count > 0) begin
          r.ok       = 1'b1;
          r.word_out = table_words[0];
        end
      end
      ACT_BACK: begin
        if (table_count > 0) begin
          r.ok       = 1'b1;
          r.word_out = table_words[table_count-1];
        end
      end
      ACT_CLEAR: begin
        table_count = 0;
        r.ok        = 1'b1;
      end
      default: ;
    endcase
    r.count_now = CNT_OUT_W'(table_count);
    r.is_empty  = (table_count == 0);
    return r;
  endfunction

  // Send one request; valid stays high into the next call unless a gap is taken
  task automatic issue_op(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                          input logic [WORD_W-1:0] word, input logic typed,
                          input op_result_t res);
    op_result_t predicted;
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.position <= pos;
    req_ch.word_in  <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // transfer taken at this edge
    predicted = apply_op(act, pos, word);
    pending_results.push_back(typed ? res : predicted);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    if (table_count == 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom);
    return POS_W'($urandom_range(0, table_count - 1));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // One random operation; grow_pct sets the share of push and insert
  task automatic random_op(input int grow_pct);
    logic [ACT_W-1:0] act;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      act = ACT_W'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
    end else if (r < 5) begin
      act = ACT_CLEAR;
    end else if (r < 5 + grow_pct) begin
      act = $urandom_range(0, 1) ? ACT_PUSH : ACT_INSERT;
    end else begin
      case ($urandom_range(0, 5))
        0:       act = ACT_GET;
        1:       act = ACT_SET;
        2:       act = ACT_POP;
        3:       act = ACT_REMOVE;
        4:       act = ACT_FRONT;
        default: act = ACT_BACK;
      endcase
    end
    issue_op(act, pick_position(), pick_word(), 1'b0, '0);
  endtask

  // Response sink with random back-pressure bursts
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      rsp_ch.ready <= (ready_hold == 0);
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      ready_hold = $urandom_range(1, 15);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Compare each response transfer with the oldest expectation
  always @(posedge clk) begin
    op_result_t exp_res;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("response transfer with no request outstanding");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_ch.ok !== exp_res.ok) begin
          $error("ok: expected %0d actual %0d", exp_res.ok, rsp_ch.ok);
          error_count++;
        end
        if (rsp_ch.word_out !== exp_res.word_out) begin
          $error("word_out: expected %h actual %h", exp_res.word_out, rsp_ch.word_out);
          error_count++;
        end
        if (rsp_ch.count_now !== exp_res.count_now) begin
          $error("count_now: expected %0d actual %0d", exp_res.count_now, rsp_ch.count_now);
          error_count++;
        end
        if (rsp_ch.is_empty !== exp_res.is_empty) begin
          $error("is_empty: expected %0d actual %0d", exp_res.is_empty, rsp_ch.is_empty);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    table_count     = 0;
    stalls_on       = 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_GET;
    req_ch.position <= '0;
    req_ch.word_in  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      issue_op(directed[i].act, directed[i].pos, directed[i].word, directed[i].typed,
               directed[i].res);
    end

    // random mix at moderate fill
    repeat (500) random_op(30);

    // hold the sender until the block has answered everything
    req_ch.valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    // fill to capacity with appends and inserts anywhere
    while (table_count < TABLE_DEPTH) begin
      if ($urandom_range(0, 4) < 3) begin
        issue_op(ACT_PUSH, POS_W'($urandom), pick_word(), 1'b0, '0);
      end else begin
        issue_op(ACT_INSERT, pick_position(), pick_word(), 1'b0, '0);
      end
    end

    // full table: rejected growth, longest shifts, top index
    issue_op(ACT_PUSH, 8'd0, pick_word(), 1'b0, '0);
    issue_op(ACT_INSERT, 8'd0, pick_word(), 1'b0, '0);
    issue_op(ACT_GET, 8'd255, '0, 1'b0, '0);
    issue_op(ACT_SET, 8'd255, pick_word(), 1'b0, '0);
    issue_op(ACT_REMOVE, 8'd0, '0, 1'b0, '0);
    issue_op(ACT_INSERT, 8'd0, pick_word(), 1'b0, '0);
    issue_op(ACT_REMOVE, 8'd255, '0, 1'b0, '0);
    issue_op(ACT_INSERT, 8'd255, pick_word(), 1'b0, '0);
    repeat (30) random_op(50);

    // drain to empty
    while (table_count > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        issue_op(ACT_REMOVE, pick_position(), '0, 1'b0, '0);
      end else begin
        issue_op(ACT_POP, '0, '0, 1'b0, '0);
      end
    end
    issue_op(ACT_POP, '0, '0, 1'b0, '0);
    issue_op(ACT_BACK, '0, '0, 1'b0, '0);
    issue_op(ACT_CLEAR, '0, '0, 1'b0, '0);

    // final stretch without idling on either side
    stalls_on = 1'b0;
    repeat (250) random_op(30);

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ordt_pkg.sv
rtl/ordt_ifs.sv
rtl/ordt_mem.sv
rtl/ordt_ctrl.sv
rtl/ordered_array_table.sv
tb/ordered_array_table_test.sv
